FILE: rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types, codes and helper functions of the subcode Q channel generator.
// ----------------------------------------------------------------------------
package cdq_pkg;

   // request codes
   localparam logic [1:0] REQ_READ    = 2'd0;
   localparam logic [1:0] REQ_ADVANCE = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   // frame kinds
   localparam logic [1:0] KIND_AUDIO    = 2'd0;
   localparam logic [1:0] KIND_LEAD_IN  = 2'd1;
   localparam logic [1:0] KIND_LEAD_OUT = 2'd2;

   // register indexes
   localparam logic CSR_TRACK      = 1'b0;
   localparam logic CSR_FRAME_KIND = 1'b1;

   // frame constants
   localparam logic [7:0]  Q_CONTROL_ADR = 8'h04;
   localparam logic [7:0]  Q_X_INDEX     = 8'h01;
   localparam logic [7:0]  Q_POINT_ZERO  = 8'h00;
   localparam logic [7:0]  Q_TNO_LEADIN  = 8'h00;
   localparam logic [7:0]  Q_TNO_LEADOUT = 8'h99;
   localparam logic [7:0]  Q_ZERO_BYTE   = 8'h00;
   localparam logic [7:0]  Q_BIT_MASK    = 8'h40;
   localparam logic [15:0] CRC_POLY      = 16'h1021;
   localparam logic [15:0] CRC_INVERT    = 16'hFFFF;
   localparam int          CRC_BYTES     = 10;
   localparam int          FRAME_BITS    = 96;
   localparam logic [6:0]  SYMBOL_FIRST  = 7'd2;
   localparam logic [6:0]  SYMBOL_LAST   = 7'd97;
   localparam logic [6:0]  BCD_MAX       = 7'd99;

   typedef struct packed {
      logic advance;
      logic restart;
   } cdq_cmd_type;

   // Binary 0..127 to two BCD digits, clamped at 99; tens by reciprocal 205/2048.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [6:0]  c;
      logic [14:0] p;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      c        = (v > BCD_MAX) ? BCD_MAX : v;
      p        = 15'(c) * 15'd205;
      tens     = p[14:11];
      tens_x10 = 7'(tens) * 7'd10;
      ones     = c - tens_x10;
      return {tens, ones[3:0]};
   endfunction

   // One byte of CRC-16 CCITT, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int b = 0; b < 8; b++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

FILE: rtl/cdq_crc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_crc
// Parallel inverted CRC-16 CCITT over the ten data bytes of a Q frame.
// ----------------------------------------------------------------------------
module cdq_crc (
   input  logic [79:0] data_bytes,
   output logic [15:0] crc
);
   import cdq_pkg::*;

   always_comb begin
      logic [15:0] c;
      c = 16'h0000;
      for (int i = 0; i < CRC_BYTES; i++) begin
         c = crc_byte(c, data_bytes[79 - 8*i -: 8]);
      end
      crc = c ^ CRC_INVERT;
   end

endmodule

FILE: rtl/cdq_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_frame
// Holds the Q frame as BCD time counters plus TNO and X bytes; adds the CRC.
// ----------------------------------------------------------------------------
module cdq_frame (
   input  logic                 clock,
   input  logic                 reset,
   input  cdq_pkg::cdq_cmd_type cmd,
   input  logic [6:0]           track_sel,
   input  logic [1:0]           frame_kind,
   output logic [95:0]          q_frame
);
   import cdq_pkg::*;

   logic [3:0] min_t_ff, min_t_in;
   logic [3:0] min_o_ff, min_o_in;
   logic [2:0] sec_t_ff, sec_t_in;
   logic [3:0] sec_o_ff, sec_o_in;
   logic [2:0] frm_t_ff, frm_t_in;
   logic [3:0] frm_o_ff, frm_o_in;
   logic [7:0] tno_ff, tno_in;
   logic [7:0] xp_ff, xp_in;
   logic       at_limit;
   logic [7:0] mn, sc, fr;
   logic [15:0] crc;

   assign at_limit = (min_t_ff == 4'd9) && (min_o_ff == 4'd9) && (sec_t_ff == 3'd5) &&
                     (sec_o_ff == 4'd9) && (frm_t_ff == 3'd7) && (frm_o_ff == 4'd4);

   always_comb begin
      min_t_in = min_t_ff;
      min_o_in = min_o_ff;
      sec_t_in = sec_t_ff;
      sec_o_in = sec_o_ff;
      frm_t_in = frm_t_ff;
      frm_o_in = frm_o_ff;
      tno_in   = tno_ff;
      xp_in    = xp_ff;
      if (cmd.restart || cmd.advance) begin
         case (frame_kind)
            KIND_LEAD_IN: begin
               tno_in = Q_TNO_LEADIN;
               xp_in  = Q_POINT_ZERO;
            end
            KIND_LEAD_OUT: begin
               tno_in = Q_TNO_LEADOUT;
               xp_in  = Q_X_INDEX;
            end
            default: begin
               tno_in = to_bcd(track_sel);
               xp_in  = Q_X_INDEX;
            end
         endcase
      end
      if (cmd.restart) begin
         min_t_in = '0;
         min_o_in = '0;
         sec_t_in = '0;
         sec_o_in = '0;
         frm_t_in = '0;
         frm_o_in = '0;
      end else if (cmd.advance && !at_limit) begin
         // frame digit pair wraps at 74, seconds at 59, minutes stop at 99
         if (frm_t_ff == 3'd7 && frm_o_ff == 4'd4) begin
            frm_t_in = '0;
            frm_o_in = '0;
            if (sec_t_ff == 3'd5 && sec_o_ff == 4'd9) begin
               sec_t_in = '0;
               sec_o_in = '0;
               if (min_o_ff == 4'd9) begin
                  min_o_in = '0;
                  min_t_in = min_t_ff + 4'd1;
               end else begin
                  min_o_in = min_o_ff + 4'd1;
               end
            end else if (sec_o_ff == 4'd9) begin
               sec_o_in = '0;
               sec_t_in = sec_t_ff + 3'd1;
            end else begin
               sec_o_in = sec_o_ff + 4'd1;
            end
         end else if (frm_o_ff == 4'd9) begin
            frm_o_in = '0;
            frm_t_in = frm_t_ff + 3'd1;
         end else begin
            frm_o_in = frm_o_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_t_ff <= '0;
         min_o_ff <= '0;
         sec_t_ff <= '0;
         sec_o_ff <= '0;
         frm_t_ff <= '0;
         frm_o_ff <= '0;
         tno_ff   <= 8'h01;
         xp_ff    <= Q_X_INDEX;
      end else begin
         min_t_ff <= min_t_in;
         min_o_ff <= min_o_in;
         sec_t_ff <= sec_t_in;
         sec_o_ff <= sec_o_in;
         frm_t_ff <= frm_t_in;
         frm_o_ff <= frm_o_in;
         tno_ff   <= tno_in;
         xp_ff    <= xp_in;
      end
   end

   assign mn = {min_t_ff, min_o_ff};
   assign sc = {1'b0, sec_t_ff, sec_o_ff};
   assign fr = {1'b0, frm_t_ff, frm_o_ff};

   cdq_crc u_crc (
      .data_bytes ({Q_CONTROL_ADR, tno_ff, xp_ff, mn, sc, fr, Q_ZERO_BYTE, mn, sc, fr}),
      .crc        (crc)
   );

   assign q_frame = {Q_CONTROL_ADR, tno_ff, xp_ff, mn, sc, fr, Q_ZERO_BYTE, mn, sc, fr, crc};

endmodule

FILE: rtl/cd_subcode_q_channel_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cd_subcode_q_channel_generator_core
// Subcode Q channel generator: serves the Q bit of one symbol per request.
// ----------------------------------------------------------------------------
// Each request is one req_ transfer into an input register, a read then into
// the result register; the block sustains one request per clock while the
// result side keeps up; the limit is the read path from the frame registers
// through the parallel 80-bit CRC and the bit select. An advance (req_type 1)
// steps the 75 frames-per-second BCD time code, stopping at 99:59:74, and a
// restart (req_type 2) returns it to 00:00:00; both rebuild the frame from the
// current track number and frame kind registers, which by themselves change
// nothing. A read (req_type 0) returns one rsp_ transfer with the Q bit at
// bit 6 for symbols 2..97 and rsp_symbol_error with a zero byte otherwise.
// Reads see every earlier advance or restart. No result comes for other
// requests. Write csr_ registers only while the block is idle.
// ----------------------------------------------------------------------------
module cd_subcode_q_channel_generator_core (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [6:0] req_symbol_index,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_subcode_byte,
   output logic       rsp_symbol_error,
   // register writes
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data
);
   import cdq_pkg::*;

   // configuration
   logic [6:0] track_ff;
   logic [1:0] kind_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_type_ff;
   logic [6:0] in_sym_ff;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_err_ff;

   logic        is_read;
   logic        out_free;
   logic        stage_go;
   cdq_cmd_type cmd;
   logic [95:0] q_frame;
   logic        sym_ok;
   logic [6:0]  k;
   logic [6:0]  bit_pos;
   logic        q_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         track_ff <= 7'd1;
         kind_ff  <= KIND_AUDIO;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TRACK:      track_ff <= csr_write_data;
            CSR_FRAME_KIND: kind_ff  <= csr_write_data[1:0];
            default:        ;
         endcase
      end
   end

   // Advance the held request unless it is a read and the result slot is busy.
   assign is_read   = (in_type_ff == REQ_READ);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stage_go  = in_valid_ff && (!is_read || out_free);
   assign req_ready = !in_valid_ff || stage_go;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Capture payload on each accepted transfer.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_type_ff <= req_type;
         in_sym_ff  <= req_symbol_index;
      end
   end

   // Commands update the frame at the end of their stage cycle, so the next
   // read already sees the new frame.
   assign cmd.advance = stage_go && (in_type_ff == REQ_ADVANCE);
   assign cmd.restart = stage_go && (in_type_ff == REQ_RESTART);

   cdq_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .track_sel    (track_ff),
      .frame_kind   (kind_ff),
      .q_frame      (q_frame)
   );

   // Symbol s maps to frame bit s-2 counted from the MSB of byte 0.
   assign sym_ok  = (in_sym_ff >= SYMBOL_FIRST) && (in_sym_ff <= SYMBOL_LAST);
   assign k       = in_sym_ff - SYMBOL_FIRST;
   assign bit_pos = 7'(FRAME_BITS - 1) - k;
   assign q_bit   = sym_ok ? q_frame[bit_pos] : 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_go && is_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the result; hold it while the consumer stalls.
   always_ff @(posedge clock) begin
      if (stage_go && is_read) begin
         rsp_byte_ff <= q_bit ? Q_BIT_MASK : Q_ZERO_BYTE;
         rsp_err_ff  <= !sym_ok;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_subcode_byte = rsp_byte_ff;
   assign rsp_symbol_error = rsp_err_ff;

endmodule

FILE: tb/sv/tb_cd_subcode_q_channel_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cd_subcode_q_channel_generator_core
// Self-checking bench for the subcode Q channel generator core. A short
// directed table covers reset values, symbol range edges and every request
// code. Randomized phases follow, under changing register settings and
// flow-control patterns, with short bursts of advances that move the seconds
// digits. A local model of the Q frame predicts every read without a pinned
// result. Results are matched in order, field by field.
// ----------------------------------------------------------------------------
module tb_cd_subcode_q_channel_generator_core;
   import cdq_pkg::*;

   // request and kind codes the block ignores or treats as the default
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int          SETTLE_CYCLES    = 4;    // covers input and result registers
   localparam int          ITEMS_PER_PHASE  = 105;
   localparam int          RANDOM_PHASES    = 8;
   localparam int          HOLD_OFF_CYCLES  = 300;
   localparam int          MAX_REPORTS      = 10;
   localparam logic [18:0] SECTION_LAST     = 19'd449999;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [7:0] subcode;
      logic       error_flag;
   } q_result_type;

   typedef struct packed {
      logic [1:0] req_code;
      logic [6:0] symbol;
      logic       pinned;
      logic [7:0] subcode;
      logic       error_flag;
   } stim_row_type;

   // ------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------------
   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_ready;
   logic [1:0] req_type         = REQ_READ;
   logic [6:0] req_symbol_index = '0;
   logic       rsp_valid;
   logic       rsp_ready        = 1'b0;
   logic [7:0] rsp_subcode_byte;
   logic       rsp_symbol_error;
   logic       csr_write_enable = 1'b0;
   logic       csr_index        = CSR_TRACK;
   logic [6:0] csr_write_data   = '0;

   // Typed-in expectation traveling with the request, updated like the payload
   logic       pin_use   = 1'b0;
   logic [7:0] pin_byte  = '0;
   logic       pin_error = 1'b0;

   cd_subcode_q_channel_generator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_symbol_index (req_symbol_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_subcode_byte (rsp_subcode_byte),
      .rsp_symbol_error (rsp_symbol_error),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Q frame model
   // ------------------------------------------------------------------------
   function automatic logic [7:0] bcd_digits(input int unsigned value);
      int unsigned v;
      v = (value > 99) ? 99 : value;
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // Byte 0 of the frame sits in bits 95:88, the inverted CRC in bits 15:0.
   function automatic logic [95:0] build_q_frame(input logic [18:0] count,
                                                 input logic [6:0]  track,
                                                 input logic [1:0]  kind);
      logic [7:0]  tno;
      logic [7:0]  xp;
      logic [7:0]  mins;
      logic [7:0]  secs;
      logic [7:0]  frames;
      logic [79:0] body;
      logic [15:0] crc;
      logic        feedback;
      int unsigned cnt;
      int          i;
      cnt = count;
      case (kind)
         KIND_LEAD_IN: begin
            tno = Q_TNO_LEADIN;
            xp  = Q_POINT_ZERO;
         end
         KIND_LEAD_OUT: begin
            tno = Q_TNO_LEADOUT;
            xp  = Q_X_INDEX;
         end
         default: begin
            tno = bcd_digits(track);
            xp  = Q_X_INDEX;
         end
      endcase
      mins   = bcd_digits(cnt / 4500);
      secs   = bcd_digits((cnt % 4500) / 75);
      frames = bcd_digits(cnt % 75);
      body   = {Q_CONTROL_ADR, tno, xp, mins, secs, frames, Q_ZERO_BYTE, mins, secs, frames};
      // serial CRC-16, MSB first, zero preset
      crc = '0;
      for (i = 79; i >= 0; i--) begin
         feedback = crc[15] ^ body[i];
         crc      = {crc[14:0], 1'b0};
         if (feedback) crc = crc ^ CRC_POLY;
      end
      return {body, crc ^ CRC_INVERT};
   endfunction

   function automatic q_result_type read_q_symbol(input logic [95:0] frame,
                                                  input logic [6:0] sym);
      int k;
      if (sym < SYMBOL_FIRST || sym > SYMBOL_LAST) return '{subcode: Q_ZERO_BYTE, error_flag: 1'b1};
      k = int'(sym) - 2;
      return '{subcode: frame[95 - k] ? Q_BIT_MASK : Q_ZERO_BYTE, error_flag: 1'b0};
   endfunction

   // ------------------------------------------------------------------------
   // Model state and expected results, tracked at every transfer
   // ------------------------------------------------------------------------
   logic [6:0]   track_model;
   logic [1:0]   kind_model;
   logic [18:0]  section_model;
   logic [95:0]  frame_model;
   q_result_type expected_q[$];
   q_result_type predicted;
   q_result_type oldest;
   int           failures = 0;

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         track_model   = 7'd1;
         kind_model    = KIND_AUDIO;
         section_model = '0;
         frame_model   = build_q_frame('0, 7'd1, KIND_AUDIO);
         expected_q.delete();
      end else begin
         // Retire a result first, so a read taken at this edge cannot match it.
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               log_failure($sformatf("result with nothing expected: byte %02h error %0b",
                                     rsp_subcode_byte, rsp_symbol_error));
            end else begin
               oldest = expected_q.pop_front();
               if (rsp_subcode_byte !== oldest.subcode || rsp_symbol_error !== oldest.error_flag)
                  log_failure($sformatf("mismatch: byte exp %02h got %02h, error exp %0b got %0b",
                                        oldest.subcode, rsp_subcode_byte,
                                        oldest.error_flag, rsp_symbol_error));
            end
         end
         // Register writes land in the model only; the frame waits for a rebuild.
         if (csr_write_enable) begin
            if (csr_index == CSR_TRACK) track_model = csr_write_data;
            else kind_model = csr_write_data[1:0];
         end
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_READ: begin
                  predicted = read_q_symbol(frame_model, req_symbol_index);
                  if (pin_use) predicted = '{subcode: pin_byte, error_flag: pin_error};
                  expected_q.push_back(predicted);
               end
               REQ_ADVANCE: begin
                  if (section_model < SECTION_LAST) section_model = section_model + 19'd1;
                  frame_model = build_q_frame(section_model, track_model, kind_model);
               end
               REQ_RESTART: begin
                  section_model = '0;
                  frame_model   = build_q_frame(section_model, track_model, kind_model);
               end
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------------
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------
   int req_gap_pct = 0;

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_SENDER: begin
            req_gap_pct   = 57;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            req_gap_pct   = 0;
            rsp_stall_pct = 57;
         end
         IDLE_BOTH: begin
            req_gap_pct   = 15;
            rsp_stall_pct = 15;
         end
         default: begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
      endcase
   endtask

   // Offer one request, holding it steady until the transfer happens.
   // Called and returns in the time step of a rising edge.
   task automatic offer(input logic [1:0] code, input logic [6:0] sym,
                        input logic pinned, input q_result_type pinned_result);
      while ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= code;
      req_symbol_index <= sym;
      pin_use          <= pinned;
      pin_byte         <= pinned_result.subcode;
      pin_error        <= pinned_result.error_flag;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait for every pending read, then let the pipeline empty.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers back to back; only called with the block idle.
   task automatic write_config(input logic [6:0] track, input logic [1:0] kind);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TRACK;
      csr_write_data   <= track;
      @(posedge clock);
      csr_index        <= CSR_FRAME_KIND;
      csr_write_data   <= 7'(kind);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [6:0] pick_symbol();
      // Mostly data symbols, now and then any index at all.
      if ($urandom_range(0, 9) == 0) return 7'($urandom_range(0, 127));
      return 7'($urandom_range(2, 97));
   endfunction

   task automatic random_request();
      int unsigned pick;
      int unsigned burst;
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
         offer(REQ_READ, pick_symbol(), 1'b0, '0);
      end else if (pick < 90) begin
         offer(REQ_ADVANCE, 7'($urandom), 1'b0, '0);
      end else if (pick < 94) begin
         offer(REQ_RESTART, 7'($urandom), 1'b0, '0);
      end else if (pick < 98) begin
         offer(REQ_UNUSED, 7'($urandom), 1'b0, '0);
      end else begin
         // run the time code ahead so the seconds digits move
         burst = $urandom_range(10, 40);
         repeat (burst) offer(REQ_ADVANCE, 7'($urandom), 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus tables
   // ------------------------------------------------------------------------
   // Reset frame is 04 01 01 00.. : symbol 7 hits bit 2 of byte 0, symbols 17
   // and 25 hit bit 0 of TNO and of X.
   stim_row_type directed_rows [21];
   logic [6:0]   phase_track [5];
   logic [1:0]   phase_kind  [5];

   initial begin
      int         row;
      int         phase;
      int         n;
      logic [6:0] track;
      logic [1:0] kind;

      directed_rows = '{
         '{REQ_READ,    7'd0,   1'b1, Q_ZERO_BYTE, 1'b1},  // below the data range
         '{REQ_READ,    7'd1,   1'b1, Q_ZERO_BYTE, 1'b1},
         '{REQ_READ,    7'd2,   1'b1, Q_ZERO_BYTE, 1'b0},  // first data symbol
         '{REQ_READ,    7'd7,   1'b1, Q_BIT_MASK,  1'b0},
         '{REQ_READ,    7'd17,  1'b1, Q_BIT_MASK,  1'b0},
         '{REQ_READ,    7'd25,  1'b1, Q_BIT_MASK,  1'b0},
         '{REQ_READ,    7'd97,  1'b0, Q_ZERO_BYTE, 1'b0},  // last data symbol
         '{REQ_READ,    7'd98,  1'b1, Q_ZERO_BYTE, 1'b1},  // one past the frame
         '{REQ_READ,    7'd127, 1'b1, Q_ZERO_BYTE, 1'b1},
         '{REQ_ADVANCE, 7'h55,  1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_READ,    7'd89,  1'b0, Q_ZERO_BYTE, 1'b0},  // inside the CRC
         '{REQ_READ,    7'd71,  1'b0, Q_ZERO_BYTE, 1'b0},  // second frame field
         '{REQ_UNUSED,  7'h2A,  1'b0, Q_ZERO_BYTE, 1'b0},  // ignored code
         '{REQ_READ,    7'd97,  1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_RESTART, 7'd127, 1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_READ,    7'd96,  1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_ADVANCE, 7'd0,   1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_ADVANCE, 7'd0,   1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_READ,    7'd68,  1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_RESTART, 7'd0,   1'b0, Q_ZERO_BYTE, 1'b0},
         '{REQ_READ,    7'd41,  1'b0, Q_ZERO_BYTE, 1'b0}
      };
      // extremes first: track 0, 99, 100 and 127; every kind incl. the spare one
      phase_track = '{7'd99, 7'd0, 7'd127, 7'd100, 7'd1};
      phase_kind  = '{KIND_LEAD_OUT, KIND_LEAD_IN, KIND_AUDIO, KIND_UNUSED, KIND_AUDIO};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table under the reset register values, no idling
      set_idle(IDLE_NONE);
      for (row = 0; row < $size(directed_rows); row++)
         offer(directed_rows[row].req_code, directed_rows[row].symbol,
               directed_rows[row].pinned,
               '{subcode: directed_rows[row].subcode, error_flag: directed_rows[row].error_flag});
      drain();

      // Random phases; cycle through the idling patterns
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 5) begin
            track = phase_track[phase];
            kind  = phase_kind[phase];
         end else begin
            track = 7'($urandom_range(0, 127));
            kind  = 2'($urandom_range(0, 3));
         end
         write_config(track, kind);
         set_idle(idle_mode_type'(phase % 4));
         if (phase == 0) begin
            // Writes alone must not rebuild: MSB of TNO still reads as track 01.
            offer(REQ_READ, 7'd10, 1'b1, '{subcode: Q_ZERO_BYTE, error_flag: 1'b0});
            // Stall the result side long enough to back up the request side.
            hold_requests++;
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            random_request();
            if (phase == 1 && n == ITEMS_PER_PHASE / 2) drain();
         end
         drain();
      end

      if (failures == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run
   initial begin
      #30_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
rtl/cdq_pkg.sv
rtl/cdq_crc.sv
rtl/cdq_frame.sv
rtl/cd_subcode_q_channel_generator_core.sv
tb/sv/tb_cd_subcode_q_channel_generator_core.sv
